### src/fplf_pkg.sv
// Shared types, widths and command codes for the four-plane track line fit.
// No dependencies; used by every module of the block by scoped names.
package fplf_pkg;

    localparam int MAX_HITS        = 8;
    localparam int SLOPE_FRAC_BITS = 16;
    localparam int NUM_PLANES      = 4;

    localparam int IDX_W   = 3;
    localparam int CNT_W   = 4;
    localparam int PLANE_W = 3;
    localparam int Z_W     = 12;
    localparam int XY_W    = 16;
    localparam int T_W     = 20;
    localparam int V_W     = 20;
    localparam int HIT_W   = 2 * XY_W + T_W;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;
    localparam int ICPT_W  = 24;
    localparam int SLOPE_W = 24;
    localparam int SLOW_W  = 32;

    // Fit sums
    localparam int SZ_W  = 14;
    localparam int SZZ_W = 26;
    localparam int D_W   = 28;
    localparam int SV_W  = 22;
    localparam int ZV_W  = 33;
    localparam int SZV_W = 35;
    localparam int NS_W  = 38;
    localparam int P1_W  = SZZ_W + SV_W + 1;
    localparam int NI_W  = SZ_W + SZV_W + 1;
    localparam int NUM_W = (NS_W + SLOPE_FRAC_BITS > NI_W) ? NS_W + SLOPE_FRAC_BITS : NI_W;
    localparam int DVW   = NUM_W + 1;
    localparam int DVS_W = D_W + 1;
    localparam int DCW   = $clog2(DVW + 1);

    localparam logic [CFG_IDX_W-1:0] CFG_PLANE1_HEIGHT = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PLANE2_HEIGHT = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PLANE3_HEIGHT = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PLANE4_HEIGHT = 8'd3;

    localparam logic [Z_W-1:0] PLANE1_RST = 12'd0;
    localparam logic [Z_W-1:0] PLANE2_RST = 12'd522;
    localparam logic [Z_W-1:0] PLANE3_RST = 12'd902;
    localparam logic [Z_W-1:0] PLANE4_RST = 12'd1739;

    localparam logic [1:0] COORD_X = 2'd0;
    localparam logic [1:0] COORD_Y = 2'd1;
    localparam logic [1:0] COORD_T = 2'd2;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_PRE_CLR,
        OP_SZZ_MAC,
        OP_DEN,
        OP_FIRST,
        OP_SV,
        OP_SZV_MAC,
        OP_NUM_S,
        OP_NUM_I1,
        OP_NUM_I2,
        OP_DIV_S,
        OP_DIV_I,
        OP_STORE_S,
        OP_STORE_I,
        OP_EMIT,
        OP_NEXT,
        OP_CLEAR
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [1:0] sel;
        logic [1:0] coord;
        logic       rd_en;
        logic [1:0] rd_sel;
        logic       cap_en;
        logic [1:0] cap_sel;
    } t_cmd;

    typedef struct packed {
        logic exists;
        logic last;
        logic div_done;
    } t_status;

endpackage

### src/fplf_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on fplf_pkg for operand widths.
module fplf_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [fplf_pkg::DVW-1:0]   i_dividend,
    input  logic [fplf_pkg::DVS_W-1:0] i_divisor,
    output logic                       o_done,
    output logic [fplf_pkg::DVW-1:0]   o_quotient
);

    logic                       r_busy;
    logic                       r_done;
    logic [fplf_pkg::DCW-1:0]   r_cnt;
    logic [fplf_pkg::DVS_W-1:0] r_rem;
    logic [fplf_pkg::DVW-1:0]   r_acc;
    logic [fplf_pkg::DVS_W-1:0] r_dsr;
    logic [fplf_pkg::DVS_W:0]   rem_sh;
    logic [fplf_pkg::DVS_W:0]   diff;
    logic                       ge;

    always_comb begin
        rem_sh = {r_rem, r_acc[fplf_pkg::DVW-1]};
        ge     = rem_sh >= {1'b0, r_dsr};
        diff   = rem_sh - {1'b0, r_dsr};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= fplf_pkg::DCW'(fplf_pkg::DVW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == fplf_pkg::DCW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_acc <= i_dividend;
            r_dsr <= i_divisor;
        end else if (r_busy) begin
            r_rem <= ge ? diff[fplf_pkg::DVS_W-1:0] : rem_sh[fplf_pkg::DVS_W-1:0];
            r_acc <= {r_acc[fplf_pkg::DVW-2:0], ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_acc;

endmodule

### src/fplf_dp.sv
// Datapath: hit buffer, combination walker, fit sums and result registers.
// Depends on fplf_pkg and instantiates fplf_div.
module fplf_dp (
    input  logic                                             i_clk,
    input  logic                                             i_rst_n,
    input  logic                                             i_load,
    input  logic [fplf_pkg::PLANE_W-1:0]                     i_plane,
    input  logic signed [fplf_pkg::XY_W-1:0]                 i_x,
    input  logic signed [fplf_pkg::XY_W-1:0]                 i_y,
    input  logic signed [fplf_pkg::T_W-1:0]                  i_t,
    input  logic [fplf_pkg::NUM_PLANES-1:0][fplf_pkg::Z_W-1:0] i_z,
    input  fplf_pkg::t_cmd                                   i_cmd,
    output fplf_pkg::t_status                                o_status,
    output logic                                             o_valid,
    output logic signed [fplf_pkg::ICPT_W-1:0]               o_x_icpt,
    output logic signed [fplf_pkg::SLOPE_W-1:0]              o_x_slope,
    output logic signed [fplf_pkg::ICPT_W-1:0]               o_y_icpt,
    output logic signed [fplf_pkg::SLOPE_W-1:0]              o_y_slope,
    output logic signed [fplf_pkg::ICPT_W-1:0]               o_t_icpt,
    output logic signed [fplf_pkg::SLOW_W-1:0]               o_slowness,
    output logic [fplf_pkg::NUM_PLANES-1:0][fplf_pkg::IDX_W-1:0] o_idx,
    output logic                                             o_last,
    output logic                                             o_dropped
);

    logic [fplf_pkg::HIT_W-1:0]   r_mem [fplf_pkg::MAX_HITS];
    logic [fplf_pkg::PLANE_W-1:0] r_plane [fplf_pkg::MAX_HITS];
    logic [fplf_pkg::CNT_W-1:0]   r_count;
    logic                         r_ovf;
    logic [fplf_pkg::HIT_W-1:0]   r_rd;
    logic signed [fplf_pkg::V_W-1:0] r_v [fplf_pkg::NUM_PLANES][3];

    logic [fplf_pkg::NUM_PLANES-1:0][fplf_pkg::MAX_HITS-1:0] match;
    logic [fplf_pkg::NUM_PLANES-1:0][fplf_pkg::IDX_W:0]      fst;
    logic [fplf_pkg::NUM_PLANES-1:0][fplf_pkg::IDX_W:0]      nxt;
    logic [fplf_pkg::NUM_PLANES-1:0][fplf_pkg::IDX_W-1:0]    r_idx;
    logic [fplf_pkg::NUM_PLANES-1:0][fplf_pkg::IDX_W-1:0]    n_idx;
    logic carry;

    logic [fplf_pkg::SZ_W-1:0]         r_sz;
    logic [fplf_pkg::SZZ_W-1:0]        r_szz;
    logic [fplf_pkg::D_W-1:0]          r_d;
    logic signed [fplf_pkg::SV_W-1:0]  r_sv;
    logic signed [fplf_pkg::SZV_W-1:0] r_szv;
    logic signed [fplf_pkg::NS_W-1:0]  r_ns;
    logic signed [fplf_pkg::P1_W-1:0]  r_p1;
    logic signed [fplf_pkg::NI_W-1:0]  r_ni;
    logic                              r_neg;
    logic                              r_valid;

    logic [fplf_pkg::Z_W-1:0]          zsel;
    logic signed [fplf_pkg::V_W-1:0]   vsel [fplf_pkg::NUM_PLANES];
    logic [2*fplf_pkg::Z_W-1:0]        zz;
    logic [fplf_pkg::D_W-1:0]          sz2;
    logic signed [fplf_pkg::ZV_W-1:0]  zv;
    logic signed [fplf_pkg::NS_W-1:0]  szv4;
    logic signed [fplf_pkg::SZ_W+fplf_pkg::SV_W:0] szsv;
    logic signed [fplf_pkg::P1_W-1:0]  p1;
    logic signed [fplf_pkg::NI_W-1:0]  p2;
    logic                              d0;
    logic signed [fplf_pkg::NUM_W-1:0] num;
    logic [fplf_pkg::NUM_W-1:0]        mag;
    logic [fplf_pkg::D_W-1:0]          dd;
    logic [fplf_pkg::DVW-1:0]          dividend;
    logic [fplf_pkg::DVS_W-1:0]        divisor;
    logic                              div_start;
    logic                              div_done;
    logic [fplf_pkg::DVW-1:0]          quot;
    logic [31:0]                       sat_s;
    logic [31:0]                       sat_i;

    function automatic logic [fplf_pkg::IDX_W:0] find_from(
        input logic [fplf_pkg::MAX_HITS-1:0] mask,
        input logic [fplf_pkg::IDX_W:0]      from
    );
        logic                       found;
        logic [fplf_pkg::IDX_W-1:0] idx;
        found = 1'b0;
        idx   = '0;
        for (int i = 0; i < fplf_pkg::MAX_HITS; i++) begin
            if (!found && mask[i] && ((fplf_pkg::IDX_W+1)'(i) >= from)) begin
                found = 1'b1;
                idx   = fplf_pkg::IDX_W'(i);
            end
        end
        return {found, idx};
    endfunction

    // Round-to-nearest quotient magnitude plus sign, clipped to a w-bit field
    function automatic logic [31:0] sat(
        input logic                     neg,
        input logic [fplf_pkg::DVW-1:0] q,
        input int                       w
    );
        logic [fplf_pkg::DVW-1:0] lim;
        logic [fplf_pkg::DVW-1:0] res;
        lim = (fplf_pkg::DVW'(1) << (w - 1)) - 1'b1;
        if (!neg) begin
            res = (q > lim) ? lim : q;
        end else begin
            res = (q > lim + 1'b1) ? -(lim + 1'b1) : -q;
        end
        return res[31:0];
    endfunction

    // Hit lookup per plane
    always_comb begin
        for (int p = 0; p < fplf_pkg::NUM_PLANES; p++) begin
            for (int i = 0; i < fplf_pkg::MAX_HITS; i++) begin
                match[p][i] = (r_plane[i] == fplf_pkg::PLANE_W'(p + 1))
                              && (fplf_pkg::CNT_W'(i) < r_count);
            end
            fst[p] = find_from(match[p], '0);
            nxt[p] = find_from(match[p], {1'b0, r_idx[p]} + 1'b1);
        end
    end

    // Odometer: innermost plane advances first, wrap to first match
    always_comb begin
        n_idx = r_idx;
        carry = 1'b1;
        for (int q = fplf_pkg::NUM_PLANES - 1; q >= 0; q--) begin
            if (carry) begin
                if (nxt[q][fplf_pkg::IDX_W]) begin
                    n_idx[q] = nxt[q][fplf_pkg::IDX_W-1:0];
                    carry    = 1'b0;
                end else begin
                    n_idx[q] = fst[q][fplf_pkg::IDX_W-1:0];
                end
            end
        end
    end

    assign o_status.exists   = fst[0][fplf_pkg::IDX_W] & fst[1][fplf_pkg::IDX_W]
                               & fst[2][fplf_pkg::IDX_W] & fst[3][fplf_pkg::IDX_W];
    assign o_status.last     = !(nxt[0][fplf_pkg::IDX_W] | nxt[1][fplf_pkg::IDX_W]
                               | nxt[2][fplf_pkg::IDX_W] | nxt[3][fplf_pkg::IDX_W]);
    assign o_status.div_done = div_done;

    // Arithmetic operands
    always_comb begin
        zsel = i_z[i_cmd.sel];
        for (int q = 0; q < fplf_pkg::NUM_PLANES; q++) begin
            vsel[q] = r_v[q][i_cmd.coord];
        end
        zz   = zsel * zsel;
        sz2  = r_sz * r_sz;
        zv   = $signed({1'b0, zsel}) * vsel[i_cmd.sel];
        szv4 = fplf_pkg::NS_W'(r_szv) <<< 2;
        szsv = $signed({1'b0, r_sz}) * r_sv;
        p1   = $signed({1'b0, r_szz}) * r_sv;
        p2   = $signed({1'b0, r_sz}) * r_szv;
        d0   = (r_d == '0);
        if (i_cmd.op == fplf_pkg::OP_DIV_S) begin
            num = d0 ? '0 : (fplf_pkg::NUM_W'(r_ns) <<< fplf_pkg::SLOPE_FRAC_BITS);
        end else begin
            num = d0 ? fplf_pkg::NUM_W'(r_sv) : fplf_pkg::NUM_W'(r_ni);
        end
        mag       = num[fplf_pkg::NUM_W-1] ? -num : num;
        dd        = d0 ? fplf_pkg::D_W'(fplf_pkg::NUM_PLANES) : r_d;
        dividend  = {mag, 1'b0} + fplf_pkg::DVW'(dd);
        divisor   = {dd, 1'b0};
        div_start = (i_cmd.op == fplf_pkg::OP_DIV_S) || (i_cmd.op == fplf_pkg::OP_DIV_I);
        sat_s     = sat(r_neg, quot, (i_cmd.coord == fplf_pkg::COORD_T)
                        ? fplf_pkg::SLOW_W : fplf_pkg::SLOPE_W);
        sat_i     = sat(r_neg, quot, fplf_pkg::ICPT_W);
    end

    fplf_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (dividend),
        .i_divisor  (divisor),
        .o_done     (div_done),
        .o_quotient (quot)
    );

    // Hit buffer
    always_ff @(posedge i_clk) begin
        if (i_load && (r_count < fplf_pkg::CNT_W'(fplf_pkg::MAX_HITS))) begin
            r_mem[r_count[fplf_pkg::IDX_W-1:0]]   <= {i_x, i_y, i_t};
            r_plane[r_count[fplf_pkg::IDX_W-1:0]] <= i_plane;
        end
        if (i_cmd.rd_en) begin
            r_rd <= r_mem[r_idx[i_cmd.rd_sel]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ovf   <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= (i_cmd.op == fplf_pkg::OP_EMIT);
            if (i_cmd.op == fplf_pkg::OP_CLEAR) begin
                r_count <= '0;
                r_ovf   <= 1'b0;
            end else if (i_load) begin
                if (r_count < fplf_pkg::CNT_W'(fplf_pkg::MAX_HITS)) begin
                    r_count <= r_count + 1'b1;
                end else begin
                    r_ovf <= 1'b1;
                end
            end
        end
    end

    // Fit registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_en) begin
            r_v[i_cmd.cap_sel][0] <= fplf_pkg::V_W'($signed(r_rd[fplf_pkg::HIT_W-1 -: fplf_pkg::XY_W]));
            r_v[i_cmd.cap_sel][1] <= fplf_pkg::V_W'($signed(r_rd[fplf_pkg::T_W +: fplf_pkg::XY_W]));
            r_v[i_cmd.cap_sel][2] <= $signed(r_rd[fplf_pkg::T_W-1:0]);
        end
        case (i_cmd.op)
            fplf_pkg::OP_PRE_CLR: begin
                r_sz  <= fplf_pkg::SZ_W'(i_z[0]) + fplf_pkg::SZ_W'(i_z[1])
                       + fplf_pkg::SZ_W'(i_z[2]) + fplf_pkg::SZ_W'(i_z[3]);
                r_szz <= '0;
            end
            fplf_pkg::OP_SZZ_MAC: r_szz <= r_szz + fplf_pkg::SZZ_W'(zz);
            fplf_pkg::OP_DEN:     r_d   <= {r_szz, 2'b00} - sz2;
            fplf_pkg::OP_FIRST: begin
                for (int q = 0; q < fplf_pkg::NUM_PLANES; q++) begin
                    r_idx[q] <= fst[q][fplf_pkg::IDX_W-1:0];
                end
            end
            fplf_pkg::OP_NEXT: r_idx <= n_idx;
            fplf_pkg::OP_SV: begin
                r_sv  <= fplf_pkg::SV_W'(vsel[0]) + fplf_pkg::SV_W'(vsel[1])
                       + fplf_pkg::SV_W'(vsel[2]) + fplf_pkg::SV_W'(vsel[3]);
                r_szv <= '0;
            end
            fplf_pkg::OP_SZV_MAC: r_szv <= r_szv + fplf_pkg::SZV_W'(zv);
            fplf_pkg::OP_NUM_S:   r_ns  <= szv4 - fplf_pkg::NS_W'(szsv);
            fplf_pkg::OP_NUM_I1:  r_p1  <= p1;
            fplf_pkg::OP_NUM_I2:  r_ni  <= fplf_pkg::NI_W'(r_p1) - p2;
            fplf_pkg::OP_DIV_S, fplf_pkg::OP_DIV_I: r_neg <= num[fplf_pkg::NUM_W-1];
            fplf_pkg::OP_STORE_S: begin
                case (i_cmd.coord)
                    fplf_pkg::COORD_X: o_x_slope  <= sat_s[fplf_pkg::SLOPE_W-1:0];
                    fplf_pkg::COORD_Y: o_y_slope  <= sat_s[fplf_pkg::SLOPE_W-1:0];
                    default:           o_slowness <= sat_s;
                endcase
            end
            fplf_pkg::OP_STORE_I: begin
                case (i_cmd.coord)
                    fplf_pkg::COORD_X: o_x_icpt <= sat_i[fplf_pkg::ICPT_W-1:0];
                    fplf_pkg::COORD_Y: o_y_icpt <= sat_i[fplf_pkg::ICPT_W-1:0];
                    default:           o_t_icpt <= sat_i[fplf_pkg::ICPT_W-1:0];
                endcase
            end
            fplf_pkg::OP_EMIT: begin
                o_idx     <= r_idx;
                o_last    <= o_status.last;
                o_dropped <= r_ovf;
            end
            default: ;
        endcase
    end

    assign o_valid = r_valid;

endmodule

### src/fplf_ctrl.sv
// Controller: sequences the per-event setup and the per-track fit steps.
// Depends on fplf_pkg for command and status types.
module fplf_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_last_hit,
    input  fplf_pkg::t_status i_status,
    output logic              o_busy,
    output fplf_pkg::t_cmd    o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE, S_PRE, S_SZZ, S_DEN, S_FIRST, S_LOAD, S_SV, S_SZV, S_NUMS,
        S_NUMI1, S_NUMI2, S_DIVS, S_WAITS, S_DIVI, S_WAITI, S_EMIT, S_NEXT, S_DONE
    } t_state;

    t_state     r_state, n_state;
    logic [2:0] r_step, n_step;
    logic [1:0] r_coord, n_coord;
    logic       r_busy;

    always_comb begin
        o_cmd       = '0;
        o_cmd.op    = fplf_pkg::OP_NONE;
        o_cmd.coord = r_coord;
        o_cmd.sel   = r_step[1:0];
        n_state     = r_state;
        n_step      = r_step;
        n_coord     = r_coord;
        unique case (r_state)
            S_IDLE: begin
                if (i_start && !r_busy && i_last_hit) begin
                    n_state = S_PRE;
                end
            end
            S_PRE: begin
                o_cmd.op = fplf_pkg::OP_PRE_CLR;
                n_state  = S_SZZ;
                n_step   = '0;
            end
            S_SZZ: begin
                o_cmd.op = fplf_pkg::OP_SZZ_MAC;
                n_step   = r_step + 1'b1;
                if (r_step == 3'd3) begin
                    n_state = S_DEN;
                end
            end
            S_DEN: begin
                o_cmd.op = fplf_pkg::OP_DEN;
                n_state  = S_FIRST;
            end
            S_FIRST: begin
                o_cmd.op = fplf_pkg::OP_FIRST;
                n_step   = '0;
                n_state  = i_status.exists ? S_LOAD : S_DONE;
            end
            S_LOAD: begin
                // read one hit a cycle, capture the previous read
                o_cmd.rd_en   = (r_step < 3'd4);
                o_cmd.rd_sel  = r_step[1:0];
                o_cmd.cap_en  = (r_step != 3'd0);
                o_cmd.cap_sel = r_step[1:0] - 1'b1;
                n_step        = r_step + 1'b1;
                if (r_step == 3'd4) begin
                    n_state = S_SV;
                    n_coord = fplf_pkg::COORD_X;
                end
            end
            S_SV: begin
                o_cmd.op = fplf_pkg::OP_SV;
                n_step   = '0;
                n_state  = S_SZV;
            end
            S_SZV: begin
                o_cmd.op = fplf_pkg::OP_SZV_MAC;
                n_step   = r_step + 1'b1;
                if (r_step == 3'd3) begin
                    n_state = S_NUMS;
                end
            end
            S_NUMS: begin
                o_cmd.op = fplf_pkg::OP_NUM_S;
                n_state  = S_NUMI1;
            end
            S_NUMI1: begin
                o_cmd.op = fplf_pkg::OP_NUM_I1;
                n_state  = S_NUMI2;
            end
            S_NUMI2: begin
                o_cmd.op = fplf_pkg::OP_NUM_I2;
                n_state  = S_DIVS;
            end
            S_DIVS: begin
                o_cmd.op = fplf_pkg::OP_DIV_S;
                n_state  = S_WAITS;
            end
            S_WAITS: begin
                if (i_status.div_done) begin
                    o_cmd.op = fplf_pkg::OP_STORE_S;
                    n_state  = S_DIVI;
                end
            end
            S_DIVI: begin
                o_cmd.op = fplf_pkg::OP_DIV_I;
                n_state  = S_WAITI;
            end
            S_WAITI: begin
                if (i_status.div_done) begin
                    o_cmd.op = fplf_pkg::OP_STORE_I;
                    if (r_coord == fplf_pkg::COORD_T) begin
                        n_state = S_EMIT;
                    end else begin
                        n_coord = r_coord + 1'b1;
                        n_state = S_SV;
                    end
                end
            end
            S_EMIT: begin
                o_cmd.op = fplf_pkg::OP_EMIT;
                n_state  = i_status.last ? S_DONE : S_NEXT;
            end
            S_NEXT: begin
                o_cmd.op = fplf_pkg::OP_NEXT;
                n_step   = '0;
                n_state  = S_LOAD;
            end
            S_DONE: begin
                o_cmd.op = fplf_pkg::OP_CLEAR;
                n_state  = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
            r_coord <= '0;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_coord <= n_coord;
            r_busy  <= (n_state != S_IDLE);
        end
    end

    assign o_busy = r_busy;

endmodule

### src/four_plane_track_line_fit_top.sv
// Four-plane straight-line track fit: top level with plane height registers.
// Depends on fplf_pkg; instantiates fplf_ctrl and fplf_dp (which holds fplf_div).
// Throughput: hits load one per cycle while busy is low. The hit marked last raises busy
// for the setup and then for each fitted track (six serial divisions dominate each fit),
// at most 16 tracks; an event with no track holds busy only for the setup and the clear.
// Reset (synchronous, active low) empties the hit buffer and restores plane heights.
module four_plane_track_line_fit_top (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [fplf_pkg::PLANE_W-1:0]         i_plane_number,
    input  logic signed [fplf_pkg::XY_W-1:0]     i_x_pos,
    input  logic signed [fplf_pkg::XY_W-1:0]     i_y_pos,
    input  logic signed [fplf_pkg::T_W-1:0]      i_hit_time,
    input  logic                                 i_last_hit,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [fplf_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [fplf_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    output logic                                 o_result_valid,
    output logic signed [fplf_pkg::ICPT_W-1:0]   o_x_intercept,
    output logic signed [fplf_pkg::SLOPE_W-1:0]  o_x_slope,
    output logic signed [fplf_pkg::ICPT_W-1:0]   o_y_intercept,
    output logic signed [fplf_pkg::SLOPE_W-1:0]  o_y_slope,
    output logic signed [fplf_pkg::ICPT_W-1:0]   o_time_intercept,
    output logic signed [fplf_pkg::SLOW_W-1:0]   o_slowness,
    output logic [fplf_pkg::IDX_W-1:0]           o_index_plane1,
    output logic [fplf_pkg::IDX_W-1:0]           o_index_plane2,
    output logic [fplf_pkg::IDX_W-1:0]           o_index_plane3,
    output logic [fplf_pkg::IDX_W-1:0]           o_index_plane4,
    output logic                                 o_last_track,
    output logic                                 o_hits_dropped
);

    logic [fplf_pkg::NUM_PLANES-1:0][fplf_pkg::Z_W-1:0]   r_z;
    logic [fplf_pkg::NUM_PLANES-1:0][fplf_pkg::IDX_W-1:0] idx;
    fplf_pkg::t_cmd    cmd;
    fplf_pkg::t_status status;
    logic              load;

    // Config writes are always taken; unknown indices drop silently
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_z[0] <= fplf_pkg::PLANE1_RST;
            r_z[1] <= fplf_pkg::PLANE2_RST;
            r_z[2] <= fplf_pkg::PLANE3_RST;
            r_z[3] <= fplf_pkg::PLANE4_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                fplf_pkg::CFG_PLANE1_HEIGHT: r_z[0] <= i_cfg_data[fplf_pkg::Z_W-1:0];
                fplf_pkg::CFG_PLANE2_HEIGHT: r_z[1] <= i_cfg_data[fplf_pkg::Z_W-1:0];
                fplf_pkg::CFG_PLANE3_HEIGHT: r_z[2] <= i_cfg_data[fplf_pkg::Z_W-1:0];
                fplf_pkg::CFG_PLANE4_HEIGHT: r_z[3] <= i_cfg_data[fplf_pkg::Z_W-1:0];
                default: ;
            endcase
        end
    end

    // A hit transaction lands in the buffer on the same edge it is accepted
    assign load = start && !busy;

    fplf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_last_hit (i_last_hit),
        .i_status   (status),
        .o_busy     (busy),
        .o_cmd      (cmd)
    );

    fplf_dp u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (load),
        .i_plane   (i_plane_number),
        .i_x       (i_x_pos),
        .i_y       (i_y_pos),
        .i_t       (i_hit_time),
        .i_z       (r_z),
        .i_cmd     (cmd),
        .o_status  (status),
        .o_valid   (o_result_valid),
        .o_x_icpt  (o_x_intercept),
        .o_x_slope (o_x_slope),
        .o_y_icpt  (o_y_intercept),
        .o_y_slope (o_y_slope),
        .o_t_icpt  (o_time_intercept),
        .o_slowness(o_slowness),
        .o_idx     (idx),
        .o_last    (o_last_track),
        .o_dropped (o_hits_dropped)
    );

    assign o_index_plane1 = idx[0];
    assign o_index_plane2 = idx[1];
    assign o_index_plane3 = idx[2];
    assign o_index_plane4 = idx[3];

    // Results only come out of a running fit
    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> busy) else $error("result strobe while idle");

    // Tracks are spaced by the fit, never back to back
    a_valid_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid) else $error("back-to-back result strobes");

    // Closing hit of an event always starts the fit
    a_last_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_last_hit) |=> busy) else $error("event end did not start fit");

endmodule
